// File: design/dfr_pkg.sv
// Package for the double-precision remainder unit: microcode types, constants and program ROM.
package dfr_pkg;

  localparam logic [63:0] QnanBits = 64'h7FF8_0000_0000_0000;
  localparam logic [62:0] InfMag   = 63'h7FF0_0000_0000_0000;
  localparam int unsigned FracW    = 52;
  localparam int unsigned ExpW     = 11;
  localparam int unsigned SigW     = FracW + 1;  // significand with hidden bit
  localparam int unsigned AccW     = SigW + 1;   // partial remainder after a left shift
  localparam int unsigned EW       = 13;         // signed working exponent
  localparam int unsigned StepW    = 4;

  typedef logic [StepW-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_SHL_X,
    OP_SHL_Y,
    OP_REDUCE,
    OP_FINAL,
    OP_SHR_X,
    OP_PACK_N,
    OP_PACK_D,
    OP_PACK_Z,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_SPECIAL,
    C_X_NORM,
    C_Y_NORM,
    C_MX_EQ_MY,
    C_EX_LE_EY,
    C_EX_POS
  } cond_e;

  localparam step_t S_CHECK  = 4'd0;
  localparam step_t S_NORM_X = 4'd1;
  localparam step_t S_NORM_Y = 4'd2;
  localparam step_t S_REDUCE = 4'd3;
  localparam step_t S_FINAL  = 4'd4;
  localparam step_t S_RENORM = 4'd5;
  localparam step_t S_RANGE  = 4'd6;
  localparam step_t S_DENORM = 4'd7;
  localparam step_t S_PACK_N = 4'd8;
  localparam step_t S_PACK_D = 4'd9;
  localparam step_t S_ZERO   = 4'd10;
  localparam step_t S_OUT    = 4'd11;

  // Control word: first condition that holds picks its target and skips the op;
  // otherwise the op runs and control moves to nxt.
  typedef struct packed {
    cond_e c1;
    step_t t1;
    cond_e c2;
    step_t t2;
    op_e   op;
    step_t nxt;
  } uword_t;

  function automatic uword_t ucode(step_t pc);
    uword_t w;
    w = '{c1: C_NEVER, t1: S_OUT, c2: C_NEVER, t2: S_OUT, op: OP_EMIT, nxt: S_OUT};
    unique case (pc)
      S_CHECK:  w = '{C_SPECIAL,  S_OUT,    C_NEVER,    S_OUT,   OP_NOP,    S_NORM_X};
      S_NORM_X: w = '{C_X_NORM,   S_NORM_Y, C_NEVER,    S_OUT,   OP_SHL_X,  S_NORM_X};
      S_NORM_Y: w = '{C_Y_NORM,   S_REDUCE, C_NEVER,    S_OUT,   OP_SHL_Y,  S_NORM_Y};
      S_REDUCE: w = '{C_MX_EQ_MY, S_ZERO,   C_EX_LE_EY, S_FINAL, OP_REDUCE, S_REDUCE};
      S_FINAL:  w = '{C_MX_EQ_MY, S_ZERO,   C_NEVER,    S_OUT,   OP_FINAL,  S_RENORM};
      S_RENORM: w = '{C_X_NORM,   S_RANGE,  C_NEVER,    S_OUT,   OP_SHL_X,  S_RENORM};
      S_RANGE:  w = '{C_EX_POS,   S_PACK_N, C_NEVER,    S_OUT,   OP_NOP,    S_DENORM};
      S_DENORM: w = '{C_EX_POS,   S_PACK_D, C_NEVER,    S_OUT,   OP_SHR_X,  S_DENORM};
      S_PACK_N: w = '{C_NEVER,    S_OUT,    C_NEVER,    S_OUT,   OP_PACK_N, S_OUT};
      S_PACK_D: w = '{C_NEVER,    S_OUT,    C_NEVER,    S_OUT,   OP_PACK_D, S_OUT};
      S_ZERO:   w = '{C_NEVER,    S_OUT,    C_NEVER,    S_OUT,   OP_PACK_Z, S_OUT};
      S_OUT:    w = '{C_NEVER,    S_OUT,    C_NEVER,    S_OUT,   OP_EMIT,   S_OUT};
      default:  w = '{C_NEVER,    S_OUT,    C_NEVER,    S_OUT,   OP_EMIT,   S_OUT};
    endcase
    return w;
  endfunction

endpackage

// File: design/double_float_remainder_unit.sv
// Special operands go from the check step straight to the output step. Other operands
// run the shift-subtract loop, which iterates once per unit of exponent difference, plus
// one shift per bit of subnormal normalization, renormalization and denormalization.
// Throughput: one transaction at a time; busy is high from accept until the done_o cycle.
// The result is on remainder_bits_o for the single cycle done_o is high; it cannot stall.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle with no result pending.
module double_float_remainder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] dividend_bits_i,
  input  logic [63:0] divisor_bits_i,
  output logic        done_o,
  output logic [63:0] remainder_bits_o
);
  import dfr_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  step_t                  pc_q, pc_d;
  logic                   special_q, special_d;
  logic                   sx_q, sx_d;
  logic [AccW-1:0]        mx_q, mx_d;
  logic [SigW-1:0]        my_q, my_d;
  logic signed [EW-1:0]   ex_q, ex_d;
  logic signed [EW-1:0]   ey_q, ey_d;
  logic [63:0]            res_q, res_d;

  uword_t                 uw;
  logic                   accept;
  logic [62:0]            ax, ay;
  logic [ExpW-1:0]        ex_fld, ey_fld;
  logic                   is_nan;
  logic                   mx_ge_my;
  logic [AccW-1:0]        diff;
  logic                   hit1, hit2;

  function automatic logic cond_true(cond_e c, logic special, logic [AccW-1:0] mx,
                                     logic [SigW-1:0] my, logic signed [EW-1:0] ex,
                                     logic signed [EW-1:0] ey);
    logic r;
    r = 1'b0;
    unique case (c)
      C_NEVER:    r = 1'b0;
      C_SPECIAL:  r = special;
      C_X_NORM:   r = mx[FracW];
      C_Y_NORM:   r = my[FracW];
      C_MX_EQ_MY: r = (mx == {1'b0, my});
      C_EX_LE_EY: r = (ex <= ey);
      C_EX_POS:   r = (ex > 0);
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  assign accept = start && !busy_q;
  assign busy   = busy_q;
  assign done_o = done_q;
  assign remainder_bits_o = res_q;

  assign ax     = dividend_bits_i[62:0];
  assign ay     = divisor_bits_i[62:0];
  assign ex_fld = dividend_bits_i[62:52];
  assign ey_fld = divisor_bits_i[62:52];
  assign is_nan = (ay == '0) || (ay > InfMag) || (ax >= InfMag);

  assign uw       = ucode(pc_q);
  assign mx_ge_my = (mx_q >= {1'b0, my_q});
  assign diff     = mx_q - {1'b0, my_q};
  assign hit1     = cond_true(uw.c1, special_q, mx_q, my_q, ex_q, ey_q);
  assign hit2     = cond_true(uw.c2, special_q, mx_q, my_q, ex_q, ey_q);

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    pc_d      = pc_q;
    special_d = special_q;
    sx_d      = sx_q;
    mx_d      = mx_q;
    my_d      = my_q;
    ex_d      = ex_q;
    ey_d      = ey_q;
    res_d     = res_q;
    if (accept) begin
      busy_d    = 1'b1;
      pc_d      = S_CHECK;
      sx_d      = dividend_bits_i[63];
      special_d = is_nan || (ax <= ay);
      // Preload the answer for the early-out cases.
      if (is_nan) begin
        res_d = QnanBits;
      end else if (ax == ay) begin
        res_d = {dividend_bits_i[63], 63'b0};
      end else begin
        res_d = dividend_bits_i;
      end
      // Subnormals enter with exponent 1 and no hidden bit; the norm loops fix them up.
      mx_d = {1'b0, (ex_fld != '0), dividend_bits_i[FracW-1:0]};
      my_d = {(ey_fld != '0), divisor_bits_i[FracW-1:0]};
      ex_d = (ex_fld != '0) ? $signed({2'b00, ex_fld}) : EW'(1);
      ey_d = (ey_fld != '0) ? $signed({2'b00, ey_fld}) : EW'(1);
    end else if (busy_q) begin
      if (hit1) begin
        pc_d = uw.t1;
      end else if (hit2) begin
        pc_d = uw.t2;
      end else begin
        pc_d = uw.nxt;
        case (uw.op)
          OP_SHL_X: begin
            mx_d = {mx_q[AccW-2:0], 1'b0};
            ex_d = ex_q - EW'(1);
          end
          OP_SHL_Y: begin
            my_d = {my_q[SigW-2:0], 1'b0};
            ey_d = ey_q - EW'(1);
          end
          OP_REDUCE: begin
            mx_d = mx_ge_my ? {diff[AccW-2:0], 1'b0} : {mx_q[AccW-2:0], 1'b0};
            ex_d = ex_q - EW'(1);
          end
          OP_FINAL: begin
            if (mx_ge_my) mx_d = diff;
          end
          OP_SHR_X: begin
            mx_d = {1'b0, mx_q[AccW-1:1]};
            ex_d = ex_q + EW'(1);
          end
          OP_PACK_N: res_d = {sx_q, ex_q[ExpW-1:0], mx_q[FracW-1:0]};
          OP_PACK_D: res_d = {sx_q, {ExpW{1'b0}}, mx_q[FracW-1:0]};
          OP_PACK_Z: res_d = {sx_q, 63'b0};
          OP_EMIT: begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pc_q   <= S_OUT;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      pc_q   <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    special_q <= special_d;
    sx_q      <= sx_d;
    mx_q      <= mx_d;
    my_q      <= my_d;
    ex_q      <= ex_d;
    ey_q      <= ey_d;
    res_q     <= res_d;
  end

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("done_o raised while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && pc_q == S_CHECK)) else $error("accept did not start program");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done_o held longer than one cycle");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (pc_q <= S_OUT)) else $error("step counter outside program");

endmodule

// File: tb/double_float_remainder_checker.sv
// Checker for the double remainder unit: predicts fmod bit patterns and scores each result.
module double_float_remainder_checker
  import dfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [63:0] dividend_bits_i,
  input  logic [63:0] divisor_bits_i,
  input  logic        done_i,
  input  logic [63:0] remainder_bits_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] SignBit   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] HiddenBit = 64'h0010_0000_0000_0000;
  localparam logic [63:0] InfBits   = {1'b0, InfMag};

  typedef struct packed {
    logic [63:0] dividend;
    logic [63:0] divisor;
    logic [63:0] remainder;
  } remainder_txn_t;

  remainder_txn_t expected_q[$];
  remainder_txn_t head;
  remainder_txn_t fresh;
  int error_count   = 0;
  int checked_count = 0;

  // Bring a nonzero operand to a significand with bit 52 set; return its exponent.
  function automatic int normalize_sig(input logic [63:0] bits, output logic [63:0] sig);
    int          e;
    int          sh;
    logic [63:0] probe;
    e   = int'(bits[62:52]);
    sig = {12'b0, bits[51:0]};
    if (e == 0) begin
      probe = bits << 12;
      while (!probe[63] && e > -64) begin
        e--;
        probe = probe << 1;
      end
      sh  = 1 - e;
      sig = (sh < 64) ? (sig << sh) : 64'b0;
    end else begin
      sig[52] = 1'b1;
    end
    return e;
  endfunction

  function automatic logic [63:0] fmod_expected(input logic [63:0] xb, input logic [63:0] yb);
    logic [63:0] sx;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] d;
    int          ex;
    int          ey;
    int          sh;
    sx = xb & SignBit;
    ax = xb & ~SignBit;
    ay = yb & ~SignBit;
    if (ay == 64'b0 || ay > InfBits || ax >= InfBits) return QnanBits;
    if (ax <= ay) return (ax == ay) ? sx : xb;
    ex = normalize_sig(xb, mx);
    ey = normalize_sig(yb, my);
    // restoring shift-subtract, one step per unit of exponent difference
    while (ex > ey) begin
      d = mx - my;
      if (!d[63]) begin
        if (d == 64'b0) return sx;
        mx = d;
      end
      mx = mx << 1;
      ex--;
    end
    d = mx - my;
    if (!d[63]) begin
      if (d == 64'b0) return sx;
      mx = d;
    end
    while (mx[63:52] == 12'b0 && mx != 64'b0) begin
      mx = mx << 1;
      ex--;
    end
    if (ex > 0) begin
      mx = (mx - HiddenBit) | (64'(ex) << 52);
    end else begin
      sh = 1 - ex;
      mx = (sh < 64) ? (mx >> sh) : 64'b0;
    end
    return mx | sx;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      // score first so a result retiring on an accept edge pairs with the older transaction
      if (done_i !== 1'b0) begin
        if (expected_q.size() == 0) begin
          error_count++;
          $display("%0t: result %h with no transaction outstanding", $realtime,
                   remainder_bits_i);
        end else begin
          head = expected_q.pop_front();
          checked_count++;
          if (remainder_bits_i !== head.remainder) begin
            error_count++;
            $display("%0t: fmod(%h, %h) expected %h, actual %h", $realtime, head.dividend,
                     head.divisor, head.remainder, remainder_bits_i);
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        fresh.dividend  = dividend_bits_i;
        fresh.divisor   = divisor_bits_i;
        fresh.remainder = fmod_expected(dividend_bits_i, divisor_bits_i);
        expected_q.push_back(fresh);
      end
      errors_o  <= error_count;
      pending_o <= expected_q.size();
      checked_o <= checked_count;
    end
  end

endmodule

// File: tb/tb_double_float_remainder_unit.sv
// Testbench top for the double remainder unit: operand stimulus, timeout and verdict.
module tb_double_float_remainder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom   = 260;
  localparam int unsigned CalmTail    = 40;
  localparam int unsigned DrainCycles = 2300;
  localparam int unsigned CycleLimit  = 3_000_000;

  localparam logic [63:0] PosZero  = 64'h0000_0000_0000_0000;
  localparam logic [63:0] NegZero  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PosOne   = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] PosTwo   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PosInf   = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NegInf   = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] QuietNan = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] SigNan   = 64'h7FF0_0000_0000_0001;
  localparam logic [63:0] MaxNorm  = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinNorm  = 64'h0010_0000_0000_0000;
  localparam logic [63:0] MinSub   = 64'h0000_0000_0000_0001;
  localparam logic [63:0] MaxSub   = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] AllOnes  = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] dividend_bits;
  logic [63:0] divisor_bits;
  logic        done;
  logic [63:0] remainder_bits;

  int          errors;
  int          pending;
  int          checked;
  int unsigned cycle_count = 0;
  int unsigned issued      = 0;

  always #1 clk_i = ~clk_i;

  double_float_remainder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .dividend_bits_i (dividend_bits),
    .divisor_bits_i  (divisor_bits),
    .done_o          (done),
    .remainder_bits_o(remainder_bits)
  );

  double_float_remainder_checker u_remainder_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .dividend_bits_i (dividend_bits),
    .divisor_bits_i  (divisor_bits),
    .done_i          (done),
    .remainder_bits_i(remainder_bits),
    .errors_o        (errors),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d transactions outstanding", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] pack_double(bit s, int unsigned e, logic [51:0] f);
    return {s, e[10:0], f};
  endfunction

  function automatic logic [51:0] random_frac();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[51:0];
  endfunction

  function automatic logic [63:0] special_value();
    logic [63:0] v;
    case ($urandom_range(0, 6))
      0:       v = PosZero;
      1:       v = PosInf;
      2:       v = QuietNan | 64'(random_frac() >> 1);
      3:       v = PosInf | 64'(random_frac() | 52'h1);
      4:       v = MinSub;
      5:       v = MaxNorm;
      default: v = PosOne;
    endcase
    v[63] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  task automatic random_operands(output logic [63:0] x, output logic [63:0] y);
    int unsigned pick;
    int unsigned ey;
    int          ex;
    int unsigned k;
    logic [63:0] ym;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      x = {$urandom, $urandom};
      y = {$urandom, $urandom};
    end else if (pick < 55) begin
      // nearby exponents keep the reduction loop short
      ey = $urandom_range(1, 2046);
      ex = int'(ey) + int'($urandom_range(0, 60)) - 3;
      if (ex > 2046) ex = 2046;
      if (ex < 0) ex = 0;
      x = pack_double(1'($urandom_range(0, 1)), ex, random_frac());
      y = pack_double(1'($urandom_range(0, 1)), ey, random_frac());
    end else if (pick < 70) begin
      // divisors with exponent field 0 to 2 and small dividends: subnormal or tiny results
      x = pack_double(1'($urandom_range(0, 1)), $urandom_range(0, 40),
                      random_frac() >> $urandom_range(0, 51));
      y = pack_double(1'($urandom_range(0, 1)), $urandom_range(0, 2),
                      random_frac() >> $urandom_range(0, 51));
    end else if (pick < 85) begin
      if ($urandom_range(0, 1) == 0) begin
        x = special_value();
        y = pack_double(1'($urandom_range(0, 1)), $urandom_range(0, 2046), random_frac());
      end else begin
        x = pack_double(1'($urandom_range(0, 1)), $urandom_range(0, 2046), random_frac());
        y = special_value();
      end
    end else begin
      // small integer multiples, exact in double; sometimes nudged off in one of the low four bits
      ym = pack_double(1'b0, $urandom_range(900, 1100), random_frac() & ~52'hFFF);
      k  = $urandom_range(1, 300);
      x  = $realtobits($bitstoreal(ym) * k);
      if ($urandom_range(0, 3) == 0) x = x ^ (64'h1 << $urandom_range(0, 3));
      x[63] = 1'($urandom_range(0, 1));
      y     = ym;
      y[63] = 1'($urandom_range(0, 1));
    end
  endtask

  // Call at a rising edge; returns at the edge that accepts the transaction.
  task automatic send_operands(input logic [63:0] x, input logic [63:0] y, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    start         <= 1'b1;
    dividend_bits <= x;
    divisor_bits  <= y;
    do @(posedge clk_i); while (busy !== 1'b0);
    issued++;
  endtask

  initial begin
    logic [63:0] x;
    logic [63:0] y;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    dividend_bits <= '0;
    divisor_bits  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero dividends and divisors
    send_operands(PosZero, PosOne, 1'b1);
    send_operands(NegZero, PosTwo, 1'b0);
    send_operands(PosOne, PosZero, 1'b1);
    send_operands(PosTwo, NegZero, 1'b0);
    // NaN and infinity on either side
    send_operands(PosOne, QuietNan, 1'b0);
    send_operands(PosOne, SigNan, 1'b1);
    send_operands(PosInf, PosOne, 1'b0);
    send_operands(NegInf, PosTwo, 1'b0);
    send_operands(QuietNan, PosOne, 1'b0);
    send_operands(AllOnes, AllOnes, 1'b1);
    send_operands(64'hC014_0000_0000_0000, PosInf, 1'b0);
    // equal magnitudes and exact multiples give signed zeros
    send_operands(64'h4014_0000_0000_0000, 64'hC014_0000_0000_0000, 1'b0);
    send_operands(64'hC014_0000_0000_0000, 64'h4014_0000_0000_0000, 1'b0);
    send_operands(64'h4018_0000_0000_0000, 64'h4008_0000_0000_0000, 1'b1);
    send_operands(64'hC018_0000_0000_0000, 64'h3FF8_0000_0000_0000, 1'b0);
    // ordinary normal result, and dividend below divisor
    send_operands(64'h4016_0000_0000_0000, PosTwo, 1'b0);
    send_operands(64'h8000_0000_0000_0001, PosOne, 1'b0);
    // widest exponent gap
    send_operands(MaxNorm, MinSub, 1'b1);
    send_operands(MaxNorm, 64'hBFF8_0000_0000_0000, 1'b0);
    // subnormal operands and subnormal results
    send_operands(MaxSub, 64'h0000_0000_0000_0003, 1'b0);
    send_operands(PosOne, 64'h0000_0000_0000_0007, 1'b0);
    send_operands(64'h8010_0000_0000_0001, MinNorm, 1'b1);
    send_operands(MinNorm, MaxSub, 1'b0);

    for (int unsigned i = 0; i < NumRandom; i++) begin
      random_operands(x, y);
      send_operands(x, y, i < NumRandom - CalmTail);
    end
    start <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d remainders from %0d operand pairs in %0d cycles", checked, issued,
             cycle_count);
    $display("Covered NaN/infinity/zero operands, subnormals, exact multiples, wide exponent gaps");
    if (errors == 0 && pending == 0 && checked == int'(issued)) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
